@@ hw/rtl/return_address_shadow_stack_unit_assert.svh @@
// assertion macros for the return address shadow stack checker
// no dependencies; expects i_clk and i_rst_n in the using scope
`ifndef RETURN_ADDRESS_SHADOW_STACK_UNIT_ASSERT_SVH
`define RETURN_ADDRESS_SHADOW_STACK_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define RASS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define RASS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rass_pkg.sv @@
// shared types and constants of the return address shadow stack
// no dependencies
package rass_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int GUEST_W       = 32;
    localparam int HOST_W        = 48;
    localparam int OP_W          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_SET   = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_CMP
    } t_state;

    typedef struct packed {
        logic                valid;
        logic [GUEST_W-1:0]  tag;
        logic [HOST_W-1:0]   host;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic clear_en;  // write one cleared row of the table
        logic accept;    // latch incoming beat
        logic do_exec;   // perform non-matching work and load result
        logic do_cmp;    // compare popped entry and load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic count_zero;
        logic op_pop;
        logic out_free;
    } t_stat;

endpackage

@@ hw/rtl/rass_ctrl.sv @@
// controller state machine of the return address shadow stack
// depends on rass_pkg
module rass_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rass_pkg::t_stat i_stat,
    output rass_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);

    rass_pkg::t_state r_state;
    rass_pkg::t_state n_state;
    logic             w_pop_busy;

    assign w_pop_busy = i_stat.op_pop && !i_stat.count_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rass_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rass_pkg::S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = rass_pkg::S_IDLE;
                end
            end
            rass_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rass_pkg::S_EXEC;
                end
            end
            rass_pkg::S_EXEC: begin
                if (w_pop_busy) begin
                    n_state = rass_pkg::S_CMP;
                end else if (i_stat.out_free) begin
                    n_state = rass_pkg::S_IDLE;
                end
            end
            rass_pkg::S_CMP: begin
                if (i_stat.out_free) begin
                    n_state = rass_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rass_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rass_pkg::S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            rass_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            rass_pkg::S_EXEC: begin
                o_cmd.do_exec = i_stat.out_free && !w_pop_busy;
            end
            rass_pkg::S_CMP: begin
                o_cmd.do_cmp = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/rass_dp.sv @@
// datapath of the return address shadow stack: stack and table memories,
// depth counter, compare and result register; depends on rass_pkg
module rass_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rass_pkg::t_cmd                i_cmd,
    output rass_pkg::t_stat               o_stat,
    input  logic                          i_cfg_wr_en,
    input  logic [rass_pkg::HOST_W-1:0]   i_cfg_wr_data,
    input  logic [rass_pkg::OP_W-1:0]     i_op,
    input  logic [rass_pkg::GUEST_W-1:0]  i_guest,
    input  logic [rass_pkg::HOST_W-1:0]   i_host,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic                          o_stack_empty,
    output logic [rass_pkg::HOST_W-1:0]   o_host_target
);

    localparam int IDX_W = rass_pkg::IDX_W;
    localparam int CNT_W = rass_pkg::CNT_W;

    logic [IDX_W-1:0]            r_stack_mem [rass_pkg::TABLE_ENTRIES];
    rass_pkg::t_entry            r_table_mem [rass_pkg::TABLE_ENTRIES];

    rass_pkg::t_op               r_op;
    logic [rass_pkg::GUEST_W-1:0] r_guest;
    logic [rass_pkg::HOST_W-1:0] r_host;
    logic [rass_pkg::HOST_W-1:0] r_miss_target;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic [IDX_W-1:0]            r_stk_rdata;
    rass_pkg::t_entry            r_tbl_rdata;
    logic [IDX_W-1:0]            r_clr_idx;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic                        r_out_empty;
    logic [rass_pkg::HOST_W-1:0] r_out_target;

    logic [CNT_W-1:0]            w_top;
    logic                        w_full;
    logic [IDX_W-1:0]            w_push_idx;
    logic                        w_push_we;
    logic                        w_tbl_we;
    logic [IDX_W-1:0]            w_tbl_waddr;
    rass_pkg::t_entry            w_tbl_wdata;
    logic [rass_pkg::GUEST_W-1:0] w_tag;
    logic [rass_pkg::HOST_W-1:0] w_dest;
    logic                        w_match;
    logic                        w_load;

    // top of stack address, full when depth reaches the table size
    assign w_top      = r_count - CNT_W'(1);
    assign w_full     = r_count[IDX_W];
    assign w_push_idx = w_full ? IDX_W'(1) : r_count[IDX_W-1:0];
    assign w_push_we  = i_cmd.do_exec && (r_op == rass_pkg::OP_PUSH);

    always_comb begin
        w_tbl_we    = 1'b0;
        w_tbl_waddr = r_clr_idx;
        w_tbl_wdata = '0;
        if (i_cmd.clear_en) begin
            w_tbl_we = 1'b1;
        end else if (i_cmd.do_exec && (r_op == rass_pkg::OP_SET)) begin
            w_tbl_we    = 1'b1;
            w_tbl_waddr = r_guest[IDX_W-1:0];
            w_tbl_wdata = '{valid: 1'b1, tag: r_guest, host: r_host};
        end
    end

    // an unwritten entry reads as tag zero pointing at the miss target
    assign w_tag   = r_tbl_rdata.valid ? r_tbl_rdata.tag : '0;
    assign w_dest  = r_tbl_rdata.valid ? r_tbl_rdata.host : r_miss_target;
    assign w_match = (w_tag == r_guest);
    assign w_load  = i_cmd.do_exec || i_cmd.do_cmp;

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_exec) begin
            case (r_op)
                rass_pkg::OP_PUSH:  n_count = w_full ? CNT_W'(2) : r_count + CNT_W'(1);
                rass_pkg::OP_FLUSH: n_count = CNT_W'(1);
                default:            n_count = r_count;
            endcase
        end else if (i_cmd.do_cmp && w_match) begin
            n_count = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_we) begin
            r_stack_mem[w_push_idx] <= r_guest[IDX_W-1:0];
        end
        r_stk_rdata <= r_stack_mem[w_top[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_table_mem[w_tbl_waddr] <= w_tbl_wdata;
        end
        r_tbl_rdata <= r_table_mem[r_stk_rdata];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= rass_pkg::t_op'(i_op);
            r_guest <= i_guest;
            r_host  <= i_host;
        end
        if (w_load) begin
            r_out_hit    <= i_cmd.do_cmp && w_match;
            r_out_empty  <= i_cmd.do_exec && (r_op == rass_pkg::OP_POP);
            r_out_target <= (i_cmd.do_cmp && w_match) ? w_dest : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_miss_target <= '0;
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_miss_target <= i_cfg_wr_data;
            end
            if (i_cmd.clear_en) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clear_last = (r_clr_idx == '1);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.op_pop     = (r_op == rass_pkg::OP_POP);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_stack_empty = r_out_empty;
    assign o_host_target = r_out_target;

endmodule

@@ hw/rtl/return_address_shadow_stack_unit.sv @@
// return address shadow stack, one beat in flight: push/set/flush and a pop on an
// empty stack go through accept and execute, other pops through stack read, table
// read and compare; the result is loaded at the end of the last step, a result still
// unread stalls that step, and the next beat is taken while the result waits
// i_rst_n is synchronous active low; after reset a pass over all 1024 entries clears the
// table valid flags, beats are held off until it ends, config writes go on
module return_address_shadow_stack_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: miss target host address
    input  logic                          i_cfg_wr_en,
    input  logic [rass_pkg::HOST_W-1:0]   i_cfg_wr_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [79:0]                   s_axis_tdata,  // guest_addr[31:0], host_addr[79:32]
    input  logic [1:0]                    s_axis_tuser,  // operation[1:0]
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // host_target[47:0]
    output logic [1:0]                    m_axis_tuser   // hit[0], stack_empty[1]
);

    rass_pkg::t_cmd  w_cmd;
    rass_pkg::t_stat w_stat;
    logic            w_hit;
    logic            w_empty;

    // sequencing: clear pass, accept, execute, optional compare for a pop
    rass_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    // memories, depth counter and the output register
    rass_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (s_axis_tuser),
        .i_guest       (s_axis_tdata[31:0]),
        .i_host        (s_axis_tdata[79:32]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_hit         (w_hit),
        .o_stack_empty (w_empty),
        .o_host_target (m_axis_tdata)
    );

    // flags of the result beat
    assign m_axis_tuser = {w_empty, w_hit};

endmodule

@@ hw/rtl/rass_checker.sv @@
// port level checks of the return address shadow stack
// depends on return_address_shadow_stack_unit_assert.svh; bound to the top level
`include "return_address_shadow_stack_unit_assert.svh"

module rass_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // a stalled result beat keeps its content
    `RASS_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled result beat changed")

    // a pop never both hits and finds the stack empty
    `RASS_ASSERT_NOW(a_flags_excl, i_m_tvalid, !(i_m_tuser[0] && i_m_tuser[1]), "hit and empty both set")

    // the target is only driven on a hit
    `RASS_ASSERT_NOW(a_target_zero, i_m_tvalid && !i_m_tuser[0], i_m_tdata == 48'd0, "target set without hit")

    // one beat in flight: no beat is taken in the cycle after an accept
    `RASS_ASSERT_NEXT(a_one_inflight, i_s_tvalid && i_s_tready, !i_s_tready, "ready right after accept")

endmodule

bind return_address_shadow_stack_unit rass_checker u_rass_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

@@ tb/tb_return_address_shadow_stack_unit.sv @@
// self-checking testbench for the return address shadow stack unit
// depends on rass_pkg and return_address_shadow_stack_unit; predicts each result beat
`timescale 1ns / 100ps

module tb_return_address_shadow_stack_unit;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat moving
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        rass_pkg::t_op                op;
        logic [rass_pkg::GUEST_W-1:0] guest;
        logic [rass_pkg::HOST_W-1:0]  host;
    } t_req_beat;

    typedef struct packed {
        logic                        hit;
        logic                        stack_empty;
        logic [rass_pkg::HOST_W-1:0] target;
    } t_ret_beat;

    // dut ports
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_wr_en = 1'b0;
    logic [rass_pkg::HOST_W-1:0]  i_cfg_wr_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [79:0]                  s_axis_tdata = '0;   // guest_addr[31:0], host_addr[79:32]
    logic [1:0]                   s_axis_tuser = '0;   // operation[1:0]
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [47:0]                  m_axis_tdata;        // host_target[47:0]
    logic [1:0]                   m_axis_tuser;        // hit[0], stack_empty[1]

    // predicted state of the block
    logic [rass_pkg::IDX_W-1:0]   ret_slots [rass_pkg::TABLE_ENTRIES];
    int                           ret_depth = 0;
    logic [rass_pkg::GUEST_W-1:0] tbl_tag   [rass_pkg::TABLE_ENTRIES];
    logic [rass_pkg::HOST_W-1:0]  tbl_host  [rass_pkg::TABLE_ENTRIES];
    logic                         tbl_valid [rass_pkg::TABLE_ENTRIES];
    logic [rass_pkg::HOST_W-1:0]  miss_host = '0;

    // stimulus and scoreboard
    t_req_beat                    req_pending [$];
    t_ret_beat                    ret_expected [$];
    logic [rass_pkg::GUEST_W-1:0] call_chain [$];  // pop key of each open call, as the generator sees it
    int                           reqs_queued = 0;
    int                           reqs_taken = 0;
    int                           mismatch_count = 0;
    int                           quiet_cycles = 0;
    logic                         req_taken = 1'b0;
    int                           src_gap = 0;
    int                           src_run = 0;
    int                           snk_stall = 0;
    int                           snk_run = 0;

    return_address_shadow_stack_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
    end

    // one request through the predicted stack and table
    function automatic t_ret_beat shadow_step(rass_pkg::t_op op,
                                              logic [rass_pkg::GUEST_W-1:0] guest,
                                              logic [rass_pkg::HOST_W-1:0] host);
        t_ret_beat                    res;
        logic [rass_pkg::IDX_W-1:0]   slot;
        logic [rass_pkg::GUEST_W-1:0] tag;
        logic [rass_pkg::HOST_W-1:0]  dest;
        res = '0;
        case (op)
            rass_pkg::OP_PUSH: begin
                // overflow: collapse to the bottom slot before pushing
                if (ret_depth >= rass_pkg::TABLE_ENTRIES) ret_depth = 1;
                ret_slots[rass_pkg::IDX_W'(ret_depth)] = guest[rass_pkg::IDX_W-1:0];
                ret_depth++;
            end
            rass_pkg::OP_POP: begin
                if (ret_depth == 0) begin
                    res.stack_empty = 1'b1;
                end else begin
                    slot = ret_slots[rass_pkg::IDX_W'(ret_depth-1)];
                    // an entry never set reads as tag 0 pointing at the miss target
                    tag  = tbl_valid[slot] ? tbl_tag[slot] : '0;
                    dest = tbl_valid[slot] ? tbl_host[slot] : miss_host;
                    if (tag == guest) begin
                        res.hit    = 1'b1;
                        res.target = dest;
                        ret_depth--;
                    end
                end
            end
            rass_pkg::OP_SET: begin
                slot = guest[rass_pkg::IDX_W-1:0];
                tbl_tag[slot]   = guest;
                tbl_host[slot]  = host;
                tbl_valid[slot] = 1'b1;
            end
            default: begin
                // flush keeps the bottom slot as it is
                ret_depth = 1;
            end
        endcase
        return res;
    endfunction

    function automatic logic [rass_pkg::HOST_W-1:0] rand_host();
        return rass_pkg::HOST_W'({$urandom, $urandom});
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_req(rass_pkg::t_op op, logic [rass_pkg::GUEST_W-1:0] guest,
                             logic [rass_pkg::HOST_W-1:0] host);
        req_pending.push_back('{op: op, guest: guest, host: host});
        reqs_queued++;
    endtask

    // generator's view of a push: the real stack collapses when full
    task automatic note_call(logic [rass_pkg::GUEST_W-1:0] key);
        logic [rass_pkg::GUEST_W-1:0] bottom;
        if (call_chain.size() >= rass_pkg::TABLE_ENTRIES) begin
            bottom = call_chain[0];
            call_chain = {bottom};
        end
        call_chain.push_back(key);
    endtask

    task automatic note_flush();
        logic [rass_pkg::GUEST_W-1:0] bottom;
        if (call_chain.size() > 0) begin
            bottom = call_chain[0];
            call_chain = {bottom};
        end
    endtask

    // wait until every request is taken and every result is back, then a bit more
    task automatic settle();
        do @(negedge i_clk);
        while (reqs_taken != reqs_queued || ret_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_miss_target(logic [rass_pkg::HOST_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [rass_pkg::HOST_W-1:0] exp_v,
                                   logic [rass_pkg::HOST_W-1:0] act_v);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
        mismatch_count++;
    endtask

    // extremes, every operation and the corner cases of the stack
    task automatic directed_reqs();
        queue_req(rass_pkg::OP_POP,   32'h0000_0000, '0);             // empty stack
        queue_req(rass_pkg::OP_POP,   $urandom, rand_host());          // empty stack, any key
        queue_req(rass_pkg::OP_PUSH,  32'h0000_0005, rand_host());     // fills the bottom slot
        queue_req(rass_pkg::OP_POP,   32'h0000_1234, '0);             // unset entry, tag 0 -> miss
        queue_req(rass_pkg::OP_POP,   32'h0000_0000, '0);             // unset entry hits on key 0
        queue_req(rass_pkg::OP_SET,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_req(rass_pkg::OP_PUSH,  32'hFFFF_FFFF, '0);
        queue_req(rass_pkg::OP_POP,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_req(rass_pkg::OP_SET,   32'h0000_0000, 48'h0000_0000_0000);
        queue_req(rass_pkg::OP_PUSH,  32'h0000_0000, '0);
        queue_req(rass_pkg::OP_POP,   32'h0000_0000, '0);             // set entry with zero host
        queue_req(rass_pkg::OP_SET,   32'h8000_0400, 48'h8000_0000_0001);
        queue_req(rass_pkg::OP_PUSH,  32'h8000_0400, '0);
        queue_req(rass_pkg::OP_PUSH,  32'h0000_0400, '0);             // same index, other tag
        queue_req(rass_pkg::OP_POP,   32'h0000_0400, '0);             // tag mismatch, stack kept
        queue_req(rass_pkg::OP_POP,   32'h8000_0400, '0);
        queue_req(rass_pkg::OP_POP,   32'h8000_0400, '0);             // bottom slot, index 0
        queue_req(rass_pkg::OP_PUSH,  32'h0000_03FF, '0);             // index 1023
        queue_req(rass_pkg::OP_PUSH,  32'h0000_002A, '0);
        queue_req(rass_pkg::OP_FLUSH, $urandom, rand_host());          // depth back to 1
        queue_req(rass_pkg::OP_POP,   32'hFFFF_FFFF, '0);
        queue_req(rass_pkg::OP_FLUSH, 32'h0000_0000, '0);             // flush on an empty stack
        queue_req(rass_pkg::OP_POP,   32'hFFFF_FFFF, '0);
        queue_req(rass_pkg::OP_SET,   32'hAAAA_AAAA, 48'h5555_5555_5555);
        queue_req(rass_pkg::OP_PUSH,  32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
        queue_req(rass_pkg::OP_POP,   32'hAAAA_AAAA, '0);
        call_chain = {32'h0000_03FF};
    endtask

    // call/return traffic with random content, some noise and broken returns
    task automatic call_return_reqs(int count);
        int                           r;
        logic [rass_pkg::GUEST_W-1:0] ret;
        int                           made;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                // a few addresses share low indices so table entries get evicted
                if ($urandom_range(0, 2) == 0)
                    ret = ($urandom & 32'hFFFF_F000) | $urandom_range(0, 7);
                else
                    ret = $urandom;
                if ($urandom_range(0, 4) != 0) begin
                    queue_req(rass_pkg::OP_SET, ret, rand_host());
                    made++;
                    note_call(ret);
                end else begin
                    note_call('0);  // unset entry: only key 0 can hit
                end
                queue_req(rass_pkg::OP_PUSH, ret, rand_host());
                made++;
            end else if (r < 70) begin
                if (call_chain.size() > 0 && $urandom_range(0, 9) != 0)
                    ret = call_chain[$];
                else
                    ret = $urandom;
                if (call_chain.size() > 0) void'(call_chain.pop_back());
                queue_req(rass_pkg::OP_POP, ret, rand_host());
                made++;
            end else if (r < 78) begin
                queue_req(rass_pkg::OP_POP, '0, rand_host());
                made++;
            end else if (r < 82) begin
                queue_req(rass_pkg::OP_FLUSH, $urandom, rand_host());
                note_flush();
                made++;
            end else if (r < 88) begin
                queue_req(rass_pkg::OP_SET, $urandom, rand_host());
                made++;
            end else begin
                ret = $urandom;
                r = $urandom_range(0, 3);
                queue_req(rass_pkg::t_op'(r), ret, rand_host());
                if (rass_pkg::t_op'(r) == rass_pkg::OP_PUSH) note_call(ret);
                if (rass_pkg::t_op'(r) == rass_pkg::OP_FLUSH) note_flush();
                made++;
            end
        end
    endtask

    // a call chain deep enough to overrun the stack, then unwinding past the wrap
    task automatic overflow_reqs();
        logic [rass_pkg::GUEST_W-1:0] ret;
        queue_req(rass_pkg::OP_FLUSH, $urandom, rand_host());
        note_flush();
        for (int k = 0; k < rass_pkg::TABLE_ENTRIES + 6; k++) begin
            ret = $urandom;
            if (k >= rass_pkg::TABLE_ENTRIES - 2) begin
                queue_req(rass_pkg::OP_SET, ret, rand_host());
                note_call(ret);
            end else begin
                note_call('0);
            end
            queue_req(rass_pkg::OP_PUSH, ret, rand_host());
        end
        for (int k = 0; k < 12; k++) begin
            ret = (call_chain.size() > 0) ? call_chain[$] : $urandom;
            if (call_chain.size() > 0) void'(call_chain.pop_back());
            queue_req(rass_pkg::OP_POP, ret, rand_host());
        end
    endtask

    // request driver: changes inputs at the falling edge
    always @(negedge i_clk) begin
        t_req_beat beat;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
                beat = req_pending.pop_front();
                s_axis_tdata  <= {beat.host, beat.guest};
                s_axis_tuser  <= beat.op;
                s_axis_tvalid <= 1'b1;
                // stretches without any gap now and then
                if (src_run > 0) begin
                    src_run--;
                end else begin
                    src_gap = draw_pause();
                    if ($urandom_range(0, 19) == 0) src_run = $urandom_range(20, 80);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink: random backpressure, also with quiet stretches
    always @(negedge i_clk) begin
        if (snk_stall > 0) begin
            snk_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (snk_run > 0)
                snk_run--;
            else if ($urandom_range(0, 5) == 0)
                snk_stall = draw_pause();
            else if ($urandom_range(0, 49) == 0)
                snk_run = $urandom_range(20, 100);
        end
    end

    // monitor: predicts on each request beat, checks each result beat
    always @(posedge i_clk) begin
        t_ret_beat exp_beat;
        t_ret_beat act_beat;
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_wr_en) miss_host = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                ret_expected.push_back(shadow_step(rass_pkg::t_op'(s_axis_tuser),
                                                   s_axis_tdata[31:0], s_axis_tdata[79:32]));
                reqs_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                act_beat = '{hit: m_axis_tuser[0], stack_empty: m_axis_tuser[1],
                             target: m_axis_tdata};
                if (ret_expected.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %0h",
                             $time, act_beat);
                    mismatch_count++;
                end else begin
                    exp_beat = ret_expected.pop_front();
                    if (act_beat.hit != exp_beat.hit)
                        report_mismatch("hit", rass_pkg::HOST_W'(exp_beat.hit),
                                        rass_pkg::HOST_W'(act_beat.hit));
                    if (act_beat.stack_empty != exp_beat.stack_empty)
                        report_mismatch("stack_empty", rass_pkg::HOST_W'(exp_beat.stack_empty),
                                        rass_pkg::HOST_W'(act_beat.stack_empty));
                    if (act_beat.target != exp_beat.target)
                        report_mismatch("host_target", exp_beat.target, act_beat.target);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, ret_expected.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all-ones miss target while the corner cases run
        write_miss_target(48'hFFFF_FFFF_FFFF);
        directed_reqs();
        settle();

        write_miss_target('0);
        call_return_reqs(400);
        settle();

        write_miss_target(rand_host());
        overflow_reqs();
        settle();

        write_miss_target(48'h8000_0000_0001);
        call_return_reqs(250);
        settle();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
